### rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants for quaternion to Euler angle conversion
// Holds operand widths, the CORDIC arctangent table and the angle constants.
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int QUAT_W     = 16;
	localparam int FB2        = 28;
	localparam int ITERS      = 16;
	localparam int SQRT_STAGES = 16;
	localparam int NORM_BITS  = 41;
	localparam int CW         = 44;
	localparam int ZW         = 36;
	localparam int PW         = 36;
	localparam int MW         = 62;

	localparam logic signed [ZW-1:0] ANG_PI = 36'sd13493037704;
	localparam logic signed [15:0] LIM_RY = 16'sd25736;
	localparam logic signed [15:0] LIM_P  = 16'sd12868;

	typedef logic signed [QUAT_W-1:0] quat_t;

	typedef struct packed {
		logic signed [PW-1:0] rn;
		logic signed [PW-1:0] rd;
		logic signed [PW-1:0] yn;
		logic signed [PW-1:0] yd;
		logic signed [PW-1:0] a;
	} prod_t;

	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 36'sd3373259426;
			5'd1:  r = 36'sd1991351318;
			5'd2:  r = 36'sd1052175346;
			5'd3:  r = 36'sd534100635;
			5'd4:  r = 36'sd268086748;
			5'd5:  r = 36'sd134174063;
			5'd6:  r = 36'sd67103403;
			5'd7:  r = 36'sd33553749;
			5'd8:  r = 36'sd16777131;
			5'd9:  r = 36'sd8388597;
			5'd10: r = 36'sd4194303;
			5'd11: r = 36'sd2097152;
			5'd12: r = 36'sd1048576;
			5'd13: r = 36'sd524288;
			5'd14: r = 36'sd262144;
			5'd15: r = 36'sd131072;
			5'd16: r = 36'sd65536;
			5'd17: r = 36'sd32768;
			5'd18: r = 36'sd16384;
			5'd19: r = 36'sd8192;
			5'd20: r = 36'sd4096;
			5'd21: r = 36'sd2048;
			5'd22: r = 36'sd1024;
			5'd23: r = 36'sd512;
			5'd24: r = 36'sd256;
			5'd25: r = 36'sd128;
			5'd26: r = 36'sd64;
			5'd27: r = 36'sd32;
			5'd28: r = 36'sd16;
			5'd29: r = 36'sd8;
			5'd30: r = 36'sd4;
			default: r = 36'sd2;
		endcase
		return r;
	endfunction

endpackage

### rtl/q2e_cordic_step.sv
// ----------------------------------------------------------------------------
// q2e_cordic_step: one registered vectoring CORDIC rotation
// Rotates (x,y) toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module q2e_cordic_step (
	input  logic                              clk,
	input  logic                              en,
	input  logic [4:0]                        idx,
	input  logic signed [q2e_pkg::CW-1:0]     x_in,
	input  logic signed [q2e_pkg::CW-1:0]     y_in,
	input  logic signed [q2e_pkg::ZW-1:0]     z_in,
	output logic signed [q2e_pkg::CW-1:0]     x_s1,
	output logic signed [q2e_pkg::CW-1:0]     y_s1,
	output logic signed [q2e_pkg::ZW-1:0]     z_s1
);
	import q2e_pkg::*;

	logic signed [CW-1:0] xs, ys;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[CW-1]) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + atan_tab(idx);
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - atan_tab(idx);
			end
		end
	end
endmodule

### rtl/q2e_sqrt.sv
// ----------------------------------------------------------------------------
// q2e_sqrt: pipelined integer square root
// Restoring square root, two result bits per register stage, one in the last.
// ----------------------------------------------------------------------------
module q2e_sqrt (
	input  logic                              clk,
	input  logic [q2e_pkg::SQRT_STAGES-1:0]   en,
	input  logic [60:0]                       v_in,
	output logic [30:0]                       root
);
	import q2e_pkg::*;

	localparam int NB = 31;

	logic [60:0] rem_s1 [NB+1];
	logic [30:0] res_s1 [NB+1];

	assign rem_s1[0] = v_in;
	assign res_s1[0] = '0;

	for (genvar k = 0; k < NB; k++) begin : g_bit
		logic [62:0] trial;
		logic [62:0] bitv;
		logic [60:0] rem_nx;
		logic [30:0] res_nx;
		assign bitv  = 63'd1 << (2 * (NB - 1 - k));
		assign trial = ({32'd0, res_s1[k]} << (2 * (NB - k))) + bitv;
		always_comb begin
			if ({2'b0, rem_s1[k]} >= trial) begin
				rem_nx = rem_s1[k] - trial[60:0];
				res_nx = {res_s1[k][29:0], 1'b1};
			end else begin
				rem_nx = rem_s1[k];
				res_nx = {res_s1[k][29:0], 1'b0};
			end
		end
		if ((k % 2 == 1) || (k == NB - 1)) begin : g_reg
			always_ff @(posedge clk) begin
				if (en[k / 2]) begin
					rem_s1[k+1] <= rem_nx;
					res_s1[k+1] <= res_nx;
				end
			end
		end else begin : g_comb
			assign rem_s1[k+1] = rem_nx;
			assign res_s1[k+1] = res_nx;
		end
	end

	assign root = res_s1[NB];
endmodule

### rtl/q2e_atan2.sv
// ----------------------------------------------------------------------------
// q2e_atan2: pipelined atan2 with normalize, CORDIC chain and rounding
// Output angle in Q3.13, clamped to the given limit.
// ----------------------------------------------------------------------------
module q2e_atan2 (
	input  logic                             clk,
	input  logic [q2e_pkg::ITERS+2:0]        en,
	input  logic signed [q2e_pkg::MW-1:0]    y_in,
	input  logic signed [q2e_pkg::MW-1:0]    x_in,
	input  logic signed [15:0]               lim,
	output logic signed [15:0]               ang
);
	import q2e_pkg::*;

	logic [MW-1:0] ux, uy, m, ux_s1, uy_s1, ux_s2, uy_s2;
	logic yneg, zero, yneg_s1, yneg_s2, zero_s1, zero_s2;
	logic signed [ZW-1:0] off, off_s1, off_s2;
	logic [6:0] len;
	logic [6:0] len_s1;
	logic signed [CW-1:0] xn, yn;
	logic signed [CW-1:0] xc [ITERS+1];
	logic signed [CW-1:0] yc [ITERS+1];
	logic signed [ZW-1:0] zc [ITERS+1];
	logic zero_p [ITERS+1];
	logic signed [ZW-1:0] offp [ITERS+1];
	logic signed [ZW-1:0] tot;
	logic signed [ZW-20:0] r;

	always_comb begin
		logic signed [MW-1:0] xx, yy;
		zero = (x_in == '0) && (y_in == '0);
		off  = '0;
		xx   = x_in;
		yy   = y_in;
		if (x_in[MW-1]) begin
			off = y_in[MW-1] ? -ANG_PI : ANG_PI;
			xx  = -x_in;
			yy  = -y_in;
		end
		ux   = xx;
		yneg = yy[MW-1];
		uy   = yneg ? -yy : yy;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ux_s1 <= ux; uy_s1 <= uy; yneg_s1 <= yneg;
			zero_s1 <= zero; off_s1 <= off;
		end
	end

	assign m = (ux_s1 > uy_s1) ? ux_s1 : uy_s1;
	always_comb begin
		len = '0;
		for (int b = 0; b < MW; b++) if (m[b]) len = 7'(b + 1);
	end

	always_comb begin
		logic [MW-1:0] nx, ny;
		if (len_s1 > 7'(NORM_BITS)) begin
			nx = ux_s2 >> (len_s1 - 7'(NORM_BITS));
			ny = uy_s2 >> (len_s1 - 7'(NORM_BITS));
		end else begin
			nx = ux_s2 << (7'(NORM_BITS) - len_s1);
			ny = uy_s2 << (7'(NORM_BITS) - len_s1);
		end
		xn = $signed(nx[CW-1:0]);
		yn = yneg_s2 ? -$signed(ny[CW-1:0]) : $signed(ny[CW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ux_s2 <= ux_s1; uy_s2 <= uy_s1; yneg_s2 <= yneg_s1;
			len_s1 <= len; zero_s2 <= zero_s1; off_s2 <= off_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			xc[0] <= xn; yc[0] <= yn; zc[0] <= '0;
			zero_p[0] <= zero_s2; offp[0] <= off_s2;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_it
		q2e_cordic_step u_step (
			.clk(clk), .en(en[3+i]), .idx(5'(i)),
			.x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]),
			.x_s1(xc[i+1]), .y_s1(yc[i+1]), .z_s1(zc[i+1])
		);
		always_ff @(posedge clk) begin
			if (en[3+i]) begin
				zero_p[i+1] <= zero_p[i];
				offp[i+1]   <= offp[i];
			end
		end
	end

	assign tot = zero_p[ITERS] ? '0 : zc[ITERS] + offp[ITERS] + ZW'(1 << 18);
	assign r   = tot[ZW-1:19];

	always_comb begin
		if (r > 17'(lim)) ang = lim;
		else if (r < -17'(lim)) ang = -lim;
		else ang = r[15:0];
	end
endmodule

### rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: roll, pitch and yaw from a Q1.14 quaternion
// Fully pipelined; one quaternion enters per unstalled cycle, one triple leaves.
// ----------------------------------------------------------------------------
// One item per clock unless the output stalls. The pitch path runs through
// one product stage, one clamp and square stage, sixteen square root stages of
// two result bits (one in the last), three normalize stages and a sixteen-step
// CORDIC. A stalled output freezes the whole pipe and holds back the input.
module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic        m_tuser    // pitch_saturated
);
	import q2e_pkg::*;

	localparam int SQD = SQRT_STAGES;
	localparam int AD  = ITERS + 3;
	localparam int DEP = 2 + SQD + AD;

	logic adv;
	logic [DEP-1:0] vld_q;
	quat_t w, x, y, z;
	prod_t p_s1;
	logic sat_s2;
	logic [60:0] v_s2;
	logic signed [MW-1:0] a30_s2;
	logic [30:0] root;
	logic signed [MW-1:0] a_d [SQD+1];
	logic sat_d [SQD+AD+1];
	logic signed [PW-1:0] rn_d [SQD+2], rd_d [SQD+2], yn_d [SQD+2], yd_d [SQD+2];
	logic signed [15:0] roll, pitch, yaw;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[DEP-1];
	assign {w, x, y, z} = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEP-2:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.rn <= PW'(64'sd2 * (w * x + y * z));
			p_s1.rd <= PW'((64'sd1 << FB2) - 2 * (x * x + y * y));
			p_s1.yn <= PW'(64'sd2 * (w * z + x * y));
			p_s1.yd <= PW'((64'sd1 << FB2) - 2 * (y * y + z * z));
			p_s1.a  <= PW'(64'sd2 * (w * y - z * x));
		end
	end

	always_ff @(posedge clk) begin
		logic signed [29:0] ac;
		logic signed [59:0] sq;
		logic sat_c;
		if (adv) begin
			ac = p_s1.a[29:0];
			sat_c = 1'b0;
			if (p_s1.a > (PW'(1) <<< FB2)) begin
				ac = 30'sd1 <<< FB2; sat_c = 1'b1;
			end
			if (p_s1.a < -(PW'(1) <<< FB2)) begin
				ac = -(30'sd1 <<< FB2); sat_c = 1'b1;
			end
			sq = ac * ac;
			sat_s2 <= sat_c;
			a30_s2 <= MW'(ac) <<< (30 - FB2);
			v_s2 <= (61'd1 << 60) - (61'(sq) << (2 * (30 - FB2)));
		end
	end

	q2e_sqrt u_sqrt (
		.clk(clk), .en({SQD{adv}}), .v_in(v_s2), .root(root)
	);

	assign a_d[0] = a30_s2;
	assign sat_d[0] = sat_s2;
	assign rn_d[0] = p_s1.rn; assign rd_d[0] = p_s1.rd;
	assign yn_d[0] = p_s1.yn; assign yd_d[0] = p_s1.yd;
	for (genvar k = 0; k < SQD + 1; k++) begin : g_rd
		always_ff @(posedge clk) begin
			if (adv) begin
				rn_d[k+1] <= rn_d[k]; rd_d[k+1] <= rd_d[k];
				yn_d[k+1] <= yn_d[k]; yd_d[k+1] <= yd_d[k];
			end
		end
	end
	for (genvar k = 0; k < SQD; k++) begin : g_ad
		always_ff @(posedge clk) if (adv) a_d[k+1] <= a_d[k];
	end
	for (genvar k = 0; k < SQD + AD; k++) begin : g_sd
		always_ff @(posedge clk) if (adv) sat_d[k+1] <= sat_d[k];
	end

	q2e_atan2 u_pitch (
		.clk(clk), .en({AD{adv}}), .y_in(a_d[SQD]), .x_in(MW'({1'b0, root})),
		.lim(LIM_P), .ang(pitch)
	);
	q2e_atan2 u_roll (
		.clk(clk), .en({AD{adv}}), .y_in(MW'(rn_d[SQD+1])), .x_in(MW'(rd_d[SQD+1])),
		.lim(LIM_RY), .ang(roll)
	);
	q2e_atan2 u_yaw (
		.clk(clk), .en({AD{adv}}), .y_in(MW'(yn_d[SQD+1])), .x_in(MW'(yd_d[SQD+1])),
		.lim(LIM_RY), .ang(yaw)
	);

	assign m_tdata = {1'b0, yaw, pitch[14:0], roll};
	assign m_tuser = sat_d[SQD+AD];
endmodule

### rtl/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker: port-level checks for quaternion_to_euler_angles
// Watches stalls and the saturated pitch value on the result stream.
// ----------------------------------------------------------------------------
module q2e_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("item dropped");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("accept while stalled");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[30:16] == 15'd12868 || m_tdata[30:16] == 15'h4dbc)
		else $error("saturated pitch not at pole");
endmodule

bind quaternion_to_euler_angles q2e_checker u_chk (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angle converter testbench
// Streams quaternions into the converter in random bursts while the output
// side stalls on its own pattern. Each accepted quaternion is converted here
// with an exact-integer CORDIC, and the resulting angle triple and saturation
// flag are checked in order against every item that leaves the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import q2e_pkg::*;

	localparam int  CORDIC_STEPS = 16;
	localparam longint ANGLE_PI  = 64'sd13493037704;
	localparam longint TIMEOUT   = 400000;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               sat;
	} angles_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	logic [63:0] quat_queue[$];
	angles_t     angle_queue[$];
	longint      arctan_step[CORDIC_STEPS];
	int          quats_total = 0;
	int          quats_sent = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          ready_mode = 0;
	int          ready_left = 0;
	int          failures = 0;
	longint      cycles = 0;

	quaternion_to_euler_angles i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	function automatic longint arctan_pow2(int i);
		longint sum;
		longint e;
		longint term;
		longint unsigned one;
		sum = 0;
		one = 1;
		if (i == 0) begin
			return 64'sd3373259426;
		end
		for (int k = 0; k < 64; k++) begin
			e = 62 - longint'(i) * (2 * k + 1);
			if (e < 0) begin
				break;
			end
			term = longint'((one << e) / longint'(2 * k + 1));
			if (k % 2 == 1) begin
				sum -= term;
			end else begin
				sum += term;
			end
		end
		return (sum + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint vector_angle(longint yv, longint xv);
		longint off;
		longint acc;
		longint xo;
		longint unsigned ux;
		longint unsigned uy;
		longint unsigned mag;
		logic   yneg;
		int     len;
		off = 0;
		acc = 0;
		if (xv == 0 && yv == 0) begin
			return 0;
		end
		if (xv < 0) begin
			off = (yv >= 0) ? ANGLE_PI : -ANGLE_PI;
			xv = -xv;
			yv = -yv;
		end
		ux = xv;
		yneg = (yv < 0);
		uy = yneg ? longint'(-yv) : yv;
		mag = (ux > uy) ? ux : uy;
		len = 0;
		while (mag != 0) begin
			len++;
			mag >>= 1;
		end
		if (len > 41) begin
			ux >>= (len - 41);
			uy >>= (len - 41);
		end else begin
			ux <<= (41 - len);
			uy <<= (41 - len);
		end
		xv = ux;
		yv = yneg ? -longint'(uy) : longint'(uy);
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xo = xv;
			if (yv >= 0) begin
				xv = xv + (yv >>> i);
				yv = yv - (xo >>> i);
				acc += arctan_step[i];
			end else begin
				xv = xv - (yv >>> i);
				yv = yv + (xo >>> i);
				acc -= arctan_step[i];
			end
		end
		return acc + off;
	endfunction

	function automatic longint round_angle(longint ang, longint lim);
		longint r;
		r = (ang + (64'sd1 <<< 18)) >>> 19;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic angles_t euler_from_quat(logic [63:0] d);
		longint w, x, y, z, one, rn, rd, yn, yd, a, a30, c;
		angles_t r;
		w = longint'($signed(d[15:0]));
		x = longint'($signed(d[31:16]));
		y = longint'($signed(d[47:32]));
		z = longint'($signed(d[63:48]));
		one = 64'sd1 <<< FB2;
		rn = 2 * (w * x + y * z);
		rd = one - 2 * (x * x + y * y);
		yn = 2 * (w * z + x * y);
		yd = one - 2 * (y * y + z * z);
		a = 2 * (w * y - z * x);
		r.sat = 1'b0;
		if (a > one) begin
			a = one;
			r.sat = 1'b1;
		end
		if (a < -one) begin
			a = -one;
			r.sat = 1'b1;
		end
		a30 = a * (64'sd1 <<< (30 - FB2));
		c = int_sqrt((64'd1 << 60) - longint'(a30 * a30));
		r.roll = 16'(round_angle(vector_angle(rn, rd), 25736));
		r.pitch = 15'(round_angle(vector_angle(a30, c), 12868));
		r.yaw = 16'(round_angle(vector_angle(yn, yd), 25736));
		return r;
	endfunction

	function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
		logic [15:0] qw, qx, qy, qz;
		qw = 16'(w);
		qx = 16'(x);
		qy = 16'(y);
		qz = 16'(z);
		return {qz, qy, qx, qw};
	endfunction

	function automatic logic [63:0] unit_quat(int spread);
		real c[4];
		real n;
		int  v[4];
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			c[i] = real'($signed($urandom_range(2 * spread, 0)) - spread);
			n += c[i] * c[i];
		end
		if (n == 0.0) begin
			return pack_quat(16384, 0, 0, 0);
		end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++) begin
			v[i] = $rtoi(c[i] * 16384.0 / n);
		end
		return pack_quat(v[0], v[1], v[2], v[3]);
	endfunction

	// gimbal-lock region: w*y - z*x close to plus or minus one half
	function automatic logic [63:0] gimbal_quat();
		int a, b, s;
		a = $urandom_range(11800, 11400);
		b = $urandom_range(11800, 11400);
		s = $urandom_range(1, 0) ? 1 : -1;
		if ($urandom_range(1, 0)) begin
			return pack_quat(a, $urandom_range(600, 0), s * b, $urandom_range(600, 0));
		end
		return pack_quat($urandom_range(600, 0), s * a, $urandom_range(600, 0), -b);
	endfunction

	initial begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			arctan_step[i] = arctan_pow2(i);
		end
		quat_queue.push_back(pack_quat(16384, 0, 0, 0));
		quat_queue.push_back(pack_quat(0, 0, 0, 0));
		quat_queue.push_back(pack_quat(0, 16384, 0, 0));
		quat_queue.push_back(pack_quat(0, 0, 16384, 0));
		quat_queue.push_back(pack_quat(0, 0, 0, 16384));
		quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
		quat_queue.push_back(pack_quat(0, -16384, 0, 0));
		quat_queue.push_back(pack_quat(0, 0, -16384, 0));
		quat_queue.push_back(pack_quat(0, 0, 0, -16384));
		quat_queue.push_back(pack_quat(16384, 0, 16384, 0));
		quat_queue.push_back(pack_quat(16384, 0, -16384, 0));
		quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
		quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
		quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
		quat_queue.push_back(pack_quat(-16384, -16384, -16384, -16384));
		quat_queue.push_back(pack_quat(16384, 16384, 16384, 16384));
		quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
		quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
		quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
		quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
		quat_queue.push_back(pack_quat(1, 0, 0, 0));
		quat_queue.push_back(pack_quat(-1, -1, 0, 0));
		quat_queue.push_back(pack_quat(0, 0, 11585, 11585));
		for (int i = 0; i < 1330; i++) begin
			case ($urandom_range(9, 0))
				0:       quat_queue.push_back({$urandom, $urandom});
				1:       quat_queue.push_back(gimbal_quat());
				2:       quat_queue.push_back(pack_quat(
					$signed($urandom_range(32768, 0)) - 16384,
					$signed($urandom_range(32768, 0)) - 16384,
					$signed($urandom_range(32768, 0)) - 16384,
					$signed($urandom_range(32768, 0)) - 16384));
				3:       quat_queue.push_back(unit_quat(40));
				default: quat_queue.push_back(unit_quat(30000));
			endcase
		end
		quats_total = quat_queue.size();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (quats_sent == quats_total && angle_queue.size() == 0);
		repeat (80) @(posedge clk);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == TIMEOUT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				angle_queue.push_back(euler_from_quat(s_tdata));
				quats_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (quat_queue.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= quat_queue.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40, 0);
						gap_left = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(6, 1);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = $urandom_range(3, 0);
				ready_left = $urandom_range(120, 8);
			end else begin
				ready_left--;
			end
			case (ready_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(3, 0) == 0;
				default: m_tready <= 1'($urandom_range(1, 0));
			endcase
		end
	end

	always @(posedge clk) begin
		angles_t exp_a;
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_queue.size() == 0) begin
				$error("result with no quaternion outstanding");
				failures++;
			end else begin
				exp_a = angle_queue.pop_front();
				if ($signed(m_tdata[15:0]) != exp_a.roll) begin
					$error("roll_angle expected %0d actual %0d", exp_a.roll,
						$signed(m_tdata[15:0]));
					failures++;
				end
				if ($signed(m_tdata[30:16]) != exp_a.pitch) begin
					$error("pitch_angle expected %0d actual %0d", exp_a.pitch,
						$signed(m_tdata[30:16]));
					failures++;
				end
				if ($signed(m_tdata[46:31]) != exp_a.yaw) begin
					$error("yaw_angle expected %0d actual %0d", exp_a.yaw,
						$signed(m_tdata[46:31]));
					failures++;
				end
				if (m_tuser !== exp_a.sat) begin
					$error("pitch_saturated expected %0d actual %0d", exp_a.sat, m_tuser);
					failures++;
				end
			end
		end
	end

endmodule

### sim.f
rtl/q2e_pkg.sv
rtl/q2e_cordic_step.sv
rtl/q2e_sqrt.sv
rtl/q2e_atan2.sv
rtl/quaternion_to_euler_angles.sv
rtl/q2e_checker.sv
verif/testbench.sv
